// ===== rtl/core/lbpe_pkg.sv =====
// Package for the LED blink pattern engine: channel count, command and
// phase codes, and the layout of one channel record. No dependencies.
package lbpe_pkg;

  localparam int NumChannels = 4;
  localparam int ChanAw = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam logic [7:0] RepeatForever = 8'hFF;

  typedef enum logic [1:0] {
    CmdConfig  = 2'd0,
    CmdService = 2'd1,
    CmdTick    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhOn   = 2'd1,
    PhOff  = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  repeats;
    logic        fixed;
    logic        fresh;
    logic [15:0] on_dur;
    logic [15:0] off_dur;
    logic [31:0] start;
  } chan_rec_t;

  localparam int RecW = $bits(chan_rec_t);

endpackage

// ===== rtl/core/lbpe_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; read returns the contents from before a same-cycle write.
module lbpe_ram #(
  parameter int Width = 8,
  parameter int Depth = 4,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/led_blink_pattern_engine_top.sv =====
// Top level of the LED blink pattern engine: channel records in one RAM,
// shared tick counter, one result register. Uses lbpe_pkg and lbpe_ram.
//
//  channel  | handshake               | beat payload
//  ---------+-------------------------+-----------------------------------------
//  input    | in_valid_i / in_stall_o | command, channel, repeat_count,
//           |                         | off_ticks, on_ticks, steady_mode
//  output   | out_valid_o/out_stall_i | led_index, led_level
//
// One item per cycle while the output is not stalled. An input beat is registered
// in the second stage, then in the result register, which drives the result beat.
// Each record is read from the RAM on accept, modified in the second stage and
// written back as that stage moves on; a forwarding register covers back-to-back hits.
// Reset clears control flops and per-channel valid bits; an unwritten record
// reads as all zero, so no clearing pass is needed.
// A stalled output with a full result register stalls the input once the
// second stage also holds an item.
module led_blink_pattern_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [1:0]  channel_i,
  input  logic [7:0]  repeat_count_i,
  input  logic [15:0] off_ticks_i,
  input  logic [15:0] on_ticks_i,
  input  logic        steady_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  led_index_o,
  output logic        led_level_o
);

  localparam int Aw = lbpe_pkg::ChanAw;

  logic                   in_accept;
  logic                   out_free;
  logic                   s2_fire;
  logic [31:0]            tick_q;

  // second stage: item whose record is being read
  logic                   s2_valid_q;
  lbpe_pkg::cmd_e         s2_cmd_q;
  logic [1:0]             s2_chan_q;
  logic [Aw-1:0]          s2_idx_q;
  logic                   s2_inrange_q;
  logic [7:0]             s2_repeat_q;
  logic [15:0]            s2_off_q;
  logic [15:0]            s2_on_q;
  logic                   s2_steady_q;

  // record store and forwarding
  logic [lbpe_pkg::NumChannels-1:0] rec_valid_q;
  logic                   rd_valid_q;
  logic                   fwd_valid_q;
  logic [Aw-1:0]          fwd_idx_q;
  lbpe_pkg::chan_rec_t    fwd_rec_q;
  logic [lbpe_pkg::RecW-1:0] ram_rdata;
  logic                   ram_we;
  logic [Aw-1:0]          rd_idx;

  lbpe_pkg::chan_rec_t    rec_cur;
  lbpe_pkg::chan_rec_t    rec_new;
  logic                   rec_wr;
  logic                   emit;
  logic                   emit_level;
  logic [31:0]            elapsed;

  logic                   out_valid_q;
  logic [1:0]             out_index_q;
  logic                   out_level_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_fire    = s2_valid_q && out_free;
  assign in_stall_o = s2_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign rd_idx     = Aw'(channel_i);
  assign ram_we     = s2_fire && rec_wr;

  // advance the shared tick counter on a tick beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (in_accept && (command_i == lbpe_pkg::CmdTick)) begin
      tick_q <= tick_q + 32'd1;
    end
  end

  // load the second stage, hold it while the output is blocked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!s2_valid_q || out_free) begin
      s2_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s2_cmd_q     <= lbpe_pkg::cmd_e'(command_i);
      s2_chan_q    <= channel_i;
      s2_idx_q     <= rd_idx;
      s2_inrange_q <= (32'(channel_i) < lbpe_pkg::NumChannels);
      s2_repeat_q  <= repeat_count_i;
      s2_off_q     <= off_ticks_i;
      s2_on_q      <= on_ticks_i;
      s2_steady_q  <= steady_mode_i;
    end
  end

  lbpe_ram #(
    .Width (lbpe_pkg::RecW),
    .Depth (lbpe_pkg::NumChannels)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s2_idx_q),
    .wdata_i (rec_new),
    .re_i    (in_accept),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  // valid bits: an unwritten record reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (ram_we) begin
        rec_valid_q[s2_idx_q] <= 1'b1;
      end
      if (in_accept) begin
        rd_valid_q <= rec_valid_q[rd_idx];
      end
    end
  end

  // keep the last written record to cover a read that raced its write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (ram_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_idx_q <= s2_idx_q;
      fwd_rec_q <= rec_new;
    end
  end

  // modify the record: configure or one step of the phase machine (a tick beat writes nothing)
  always_comb begin
    if (fwd_valid_q && (fwd_idx_q == s2_idx_q)) begin
      rec_cur = fwd_rec_q;
    end else if (rd_valid_q) begin
      rec_cur = lbpe_pkg::chan_rec_t'(ram_rdata);
    end else begin
      rec_cur = '0;
    end
    elapsed    = tick_q - rec_cur.start;
    rec_new    = rec_cur;
    rec_wr     = 1'b0;
    emit       = 1'b0;
    emit_level = 1'b0;
    if (s2_inrange_q) begin
      case (s2_cmd_q)
        lbpe_pkg::CmdConfig: begin
          rec_new.repeats = s2_repeat_q;
          rec_new.off_dur = s2_off_q;
          rec_new.on_dur  = s2_on_q;
          rec_new.fixed   = s2_steady_q;
          rec_new.fresh   = 1'b1;
          rec_wr          = 1'b1;
        end
        lbpe_pkg::CmdService: begin
          rec_wr = 1'b1;
          case (rec_cur.phase)
            lbpe_pkg::PhIdle: begin
              if (rec_cur.fixed && rec_cur.fresh) begin
                if ((rec_cur.on_dur != '0) && (rec_cur.off_dur == '0)) begin
                  emit       = 1'b1;
                  emit_level = 1'b1;
                end else if ((rec_cur.off_dur != '0) && (rec_cur.on_dur == '0)) begin
                  emit       = 1'b1;
                  emit_level = 1'b0;
                end
                rec_new.fresh = 1'b0;
              end else if (!rec_cur.fixed && (rec_cur.repeats != '0)) begin
                rec_new.start = tick_q;
                rec_new.phase = lbpe_pkg::PhOn;
                emit          = 1'b1;
                emit_level    = 1'b1;
              end
            end
            lbpe_pkg::PhOn: begin
              if (elapsed > {16'd0, rec_cur.on_dur}) begin
                rec_new.start = tick_q;
                rec_new.phase = lbpe_pkg::PhOff;
                emit          = 1'b1;
                emit_level    = 1'b0;
              end
            end
            lbpe_pkg::PhOff: begin
              if (elapsed > {16'd0, rec_cur.off_dur}) begin
                if (rec_cur.repeats != lbpe_pkg::RepeatForever) begin
                  rec_new.repeats = rec_cur.repeats - 8'd1;
                end
                rec_new.phase = lbpe_pkg::PhIdle;
              end
            end
            default: begin
              rec_new.phase = lbpe_pkg::PhIdle;
            end
          endcase
        end
        default: begin
          rec_wr = 1'b0;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && emit) begin
      out_index_q <= s2_chan_q;
      out_level_q <= emit_level;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = out_index_q;
  assign led_level_o = out_level_q;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s2_valid_q)
    else $error("input stalled with empty second stage");

  a_write_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> s2_fire && s2_inrange_q)
    else $error("record written without a moving item");

  a_result_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire && emit |=> out_valid_q && (out_index_q == $past(s2_chan_q)))
    else $error("result lost or carries the wrong channel");

  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (command_i == lbpe_pkg::CmdTick) |=> tick_q == $past(tick_q) + 32'd1)
    else $error("tick counter did not advance");
`endif

endmodule
